// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants for the Schlick reflectance pipeline.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int IDX_W   = 16;
    localparam int RATIO_W = 18;
    localparam int COS_W   = 16;
    localparam int REFL_W  = 17;
    localparam logic [REFL_W-1:0] REFL_ONE = 17'd65536;
    localparam logic [COS_W-1:0]  COS_ONE  = 16'd32768;

endpackage

// ----- hw/rtl/sfr_pipe.sv -----
// ----------------------------------------------------------------------------
// sfr_pipe
// Fully pipelined Schlick reflectance datapath. One beat enters each cycle.
// Stage groups: index divide (one quotient bit per stage), cosine refraction
// square root (one root bit per stage), fifth power and blend.
// ----------------------------------------------------------------------------
module sfr_pipe #(
    parameter int FRACTION_BITS = sfr_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [sfr_pkg::IDX_W-1:0]   i_n1,
    input  logic [sfr_pkg::IDX_W-1:0]   i_n2,
    input  logic [sfr_pkg::RATIO_W-1:0] i_ratio,
    input  logic [sfr_pkg::COS_W-1:0]   i_cos,
    input  logic                        i_tir,
    output logic                        o_valid,
    output logic [sfr_pkg::REFL_W-1:0]  o_refl,
    output logic                        o_clamped
);

    localparam int F   = FRACTION_BITS;
    localparam int V   = F + 1;
    localparam int SW  = sfr_pkg::IDX_W + 1;
    localparam int NQ  = F + 2;
    localparam int NR  = F + 1;
    localparam int AW  = 2 * F + 2;
    localparam int PW  = 2 * V;
    localparam int RW  = sfr_pkg::RATIO_W + V;
    localparam int OW  = F + 17;
    localparam int NS  = (NQ > NR) ? NQ : NR;
    localparam logic [V-1:0] ONE  = V'(1) << F;
    localparam logic [OW-1:0] HALF = OW'(1) << (F - 1);

    // ---- stage A: decode, cosine clamp and scale ----------------------------
    logic          r_a_v, r_a_tir, r_a_den, r_a_zero;
    logic [SW-1:0] r_a_diff, r_a_sum;
    logic [V-1:0]  r_a_c;
    logic [sfr_pkg::RATIO_W-1:0] r_a_ratio;

    logic                      n_den;
    logic [sfr_pkg::COS_W-1:0] n_cos;

    always_comb begin
        n_den = i_n1 > i_n2;
        n_cos = (i_cos > sfr_pkg::COS_ONE) ? sfr_pkg::COS_ONE : i_cos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
        end
        r_a_tir   <= i_tir & n_den;
        r_a_den   <= n_den;
        r_a_diff  <= n_den ? SW'(i_n1 - i_n2) : SW'(i_n2 - i_n1);
        r_a_sum   <= SW'(i_n1) + SW'(i_n2);
        r_a_zero  <= (i_n1 == '0) && (i_n2 == '0);
        r_a_c     <= V'((F + 1 + 16)'(n_cos) << F >> 15);
        r_a_ratio <= i_ratio;
    end

    // ---- stage B: c^2 -------------------------------------------------------
    logic          r_b_v, r_b_tir, r_b_den, r_b_zero;
    logic [SW-1:0] r_b_diff, r_b_sum;
    logic [V-1:0]  r_b_c, r_b_c2;
    logic [sfr_pkg::RATIO_W-1:0] r_b_ratio;
    logic [PW-1:0] n_cc;

    assign n_cc = PW'(r_a_c) * PW'(r_a_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
        r_b_tir <= r_a_tir; r_b_den <= r_a_den; r_b_zero <= r_a_zero;
        r_b_diff <= r_a_diff; r_b_sum <= r_a_sum; r_b_c <= r_a_c;
        r_b_ratio <= r_a_ratio;
        r_b_c2 <= V'(n_cc >> F);
    end

    // ---- stage C: t = ratio*(one-c2) >> 13, start divide and root -----------
    logic          r_c_v, r_c_tir, r_c_den, r_c_zero, r_c_clamp;
    logic [SW-1:0] r_c_sum;
    logic [V-1:0]  r_c_c;
    logic [NQ+SW-1:0] r_c_num;
    logic [AW-1:0] r_c_arg;
    logic [RW-1:0] n_t;
    logic          n_clamp;
    logic [V-1:0]  n_arg;

    always_comb begin
        n_t     = (RW'(r_b_ratio) * RW'(ONE - r_b_c2)) >> 13;
        n_clamp = n_t > RW'(ONE);
        n_arg   = n_clamp ? '0 : V'(RW'(ONE) - n_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
        r_c_tir <= r_b_tir; r_c_den <= r_b_den; r_c_zero <= r_b_zero;
        r_c_sum <= r_b_sum; r_c_c <= r_b_c;
        r_c_clamp <= r_b_den & n_clamp;
        // rounded quotient: (diff*2^F + sum/2) / sum, diff < 2^SW
        r_c_num <= ((NQ + SW)'(r_b_diff) << F) + (NQ + SW)'(r_b_sum >> 1);
        r_c_arg <= AW'(n_arg) << F;
    end

    // ---- divide / root chain: one quotient bit per stage, one root bit per stage in the first NR ----
    typedef struct packed {
        logic          v, tir, den, zero, clamp;
        logic [SW-1:0] sum;
        logic [V-1:0]  c;
        logic [NQ+SW-1:0] rem;
        logic [NQ-1:0] q;
        logic [AW-1:0] sv;
        logic [NR:0]   srem;
        logic [NR-1:0] root;
    } t_it;

    t_it w_it [NS+1];

    assign w_it[0] = '{v: r_c_v, tir: r_c_tir, den: r_c_den, zero: r_c_zero,
                       clamp: r_c_clamp, sum: r_c_sum, c: r_c_c, rem: r_c_num,
                       q: '0, sv: r_c_arg, srem: '0, root: '0};

    for (genvar k = 0; k < NS; k++) begin : g_it
        localparam int QB = NQ - 1 - k;
        t_it n_s;
        t_it r_s;
        logic [NQ+SW-1:0] w_dv;
        logic [NR+1:0]    w_sr;
        logic [NR+1:0]    w_tr;
        always_comb begin
            n_s = w_it[k];
            if (QB >= 0) begin
                w_dv = (NQ + SW)'(w_it[k].sum) << ((QB >= 0) ? QB : 0);
                if (w_it[k].rem >= w_dv) begin
                    n_s.rem = w_it[k].rem - w_dv;
                    n_s.q   = w_it[k].q | (NQ'(1) << ((QB >= 0) ? QB : 0));
                end
            end else begin
                w_dv = '0;
            end
            if (k < NR) begin
                w_sr = {w_it[k].srem[NR-1:0], w_it[k].sv[AW-1 -: 2]};
                w_tr = {w_it[k].root, 2'b01};
                n_s.sv = w_it[k].sv << 2;
                if (w_sr >= w_tr) begin
                    n_s.srem = (NR + 1)'(w_sr - w_tr);
                    n_s.root = {w_it[k].root[NR-2:0], 1'b1};
                end else begin
                    n_s.srem = (NR + 1)'(w_sr);
                    n_s.root = {w_it[k].root[NR-2:0], 1'b0};
                end
            end else begin
                w_sr = '0;
                w_tr = '0;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s.v <= 1'b0;
            end else begin
                r_s.v <= n_s.v;
            end
            r_s.tir <= n_s.tir; r_s.den <= n_s.den; r_s.zero <= n_s.zero;
            r_s.clamp <= n_s.clamp; r_s.sum <= n_s.sum; r_s.c <= n_s.c;
            r_s.rem <= n_s.rem; r_s.q <= n_s.q; r_s.sv <= n_s.sv;
            r_s.srem <= n_s.srem; r_s.root <= n_s.root;
        end
        assign w_it[k+1] = r_s;
    end

    // ---- stage D: pick cosine, x = one - c; q clamp --------------------------
    logic         r_d_v, r_d_tir, r_d_zero, r_d_clamp;
    logic [V-1:0] r_d_x, r_d_q;
    logic [V-1:0] n_cs, n_q;

    always_comb begin
        n_cs = w_it[NS].den ?
            ((w_it[NS].root > ONE) ? ONE : w_it[NS].root) : w_it[NS].c;
        n_q  = (w_it[NS].q > NQ'(ONE)) ? ONE : V'(w_it[NS].q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= w_it[NS].v;
        end
        r_d_tir <= w_it[NS].tir; r_d_zero <= w_it[NS].zero;
        r_d_clamp <= w_it[NS].clamp;
        r_d_x <= ONE - n_cs;
        r_d_q <= n_q;
    end

    // ---- stage E: x^2, q^2 -> r0 --------------------------------------------
    logic         r_e_v, r_e_tir, r_e_clamp;
    logic [V-1:0] r_e_x, r_e_x2, r_e_r0;
    logic [PW-1:0] n_xx, n_qq;
    logic [V-1:0]  n_r0;

    always_comb begin
        n_xx = PW'(r_d_x) * PW'(r_d_x);
        n_qq = (PW'(r_d_q) * PW'(r_d_q) + PW'(HALF)) >> F;
        n_r0 = r_d_zero ? '0 : ((n_qq > PW'(ONE)) ? ONE : V'(n_qq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= r_d_v;
        end
        r_e_tir <= r_d_tir; r_e_clamp <= r_d_clamp; r_e_x <= r_d_x;
        r_e_x2 <= V'(n_xx >> F);
        r_e_r0 <= n_r0;
    end

    // ---- stage F: x^4 ---------------------------------------------------------
    logic         r_f_v, r_f_tir, r_f_clamp;
    logic [V-1:0] r_f_x, r_f_x4, r_f_r0;
    logic [PW-1:0] n_x4;

    assign n_x4 = PW'(r_e_x2) * PW'(r_e_x2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_e_v;
        end
        r_f_tir <= r_e_tir; r_f_clamp <= r_e_clamp; r_f_x <= r_e_x;
        r_f_r0 <= r_e_r0;
        r_f_x4 <= V'(n_x4 >> F);
    end

    // ---- stage G: x^5 ---------------------------------------------------------
    logic         r_g_v, r_g_tir, r_g_clamp;
    logic [V-1:0] r_g_x5, r_g_r0;
    logic [PW-1:0] n_x5;

    assign n_x5 = PW'(r_f_x4) * PW'(r_f_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else begin
            r_g_v <= r_f_v;
        end
        r_g_tir <= r_f_tir; r_g_clamp <= r_f_clamp; r_g_r0 <= r_f_r0;
        r_g_x5 <= V'(n_x5 >> F);
    end

    // ---- stage H: blend, rescale to Q1.16 -----------------------------------
    logic [PW-1:0] n_bl;
    logic [PW:0]   n_res;
    logic [V-1:0]  n_rc;
    logic [OW-1:0] n_o;
    logic [sfr_pkg::REFL_W-1:0] r_refl;
    logic r_v, r_clamp;

    always_comb begin
        n_bl  = PW'(ONE - r_g_r0) * PW'(r_g_x5);
        n_res = (PW + 1)'(r_g_r0) + (PW + 1)'(n_bl >> F);
        n_rc  = (n_res > (PW + 1)'(ONE)) ? ONE : V'(n_res);
        n_o   = ((OW'(n_rc) << 16) + HALF) >> F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= r_g_v;
        end
        r_refl  <= r_g_tir ? sfr_pkg::REFL_ONE :
                   ((n_o > OW'(sfr_pkg::REFL_ONE)) ? sfr_pkg::REFL_ONE
                                                   : sfr_pkg::REFL_W'(n_o));
        r_clamp <= r_g_clamp & ~r_g_tir;
    end

    assign o_valid   = r_v;
    assign o_refl    = r_refl;
    assign o_clamped = r_clamp;

endmodule

// ----- hw/rtl/schlick_fresnel_reflectance_top.sv -----
// ----------------------------------------------------------------------------
// schlick_fresnel_reflectance_top
// Schlick Fresnel reflectance with refraction of the cosine.
//
// Input beat: drive i_start with the indices, squared ratio, cosine and
// internal-reflection flag; the beat is taken at the edge where i_start is
// high and o_busy is low. o_busy stays low outside reset, so a beat can
// enter every cycle.
// Result beat: o_done pulses for one cycle with o_reflectance and
// o_sqrt_clamped; results leave in input order and cannot be held off.
// Pipeline depth is set by the bit-per-stage quotient of the index ratio.
// Throughput: one beat per cycle.
// Reset: synchronous, active low, drops all beats in flight; o_busy is high
// during reset.
// ----------------------------------------------------------------------------
module schlick_fresnel_reflectance_top #(
    parameter int FRACTION_BITS = sfr_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [sfr_pkg::IDX_W-1:0]   i_index_incident,
    input  logic [sfr_pkg::IDX_W-1:0]   i_index_far,
    input  logic [sfr_pkg::RATIO_W-1:0] i_ratio_squared,
    input  logic [sfr_pkg::COS_W-1:0]   i_cos_incident,
    input  logic                        i_internal_reflection,
    output logic                        o_done,
    output logic [sfr_pkg::REFL_W-1:0]  o_reflectance,
    output logic                        o_sqrt_clamped
);

    assign o_busy = ~i_rst_n;

    sfr_pipe #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_start & ~o_busy),
        .i_n1     (i_index_incident),
        .i_n2     (i_index_far),
        .i_ratio  (i_ratio_squared),
        .i_cos    (i_cos_incident),
        .i_tir    (i_internal_reflection),
        .o_valid  (o_done),
        .o_refl   (o_reflectance),
        .o_clamped(o_sqrt_clamped)
    );

endmodule

// ----- bench/tb_schlick_fresnel_reflectance_top.sv -----
// ----------------------------------------------------------------------------
// tb_schlick_fresnel_reflectance_top
// Drives index pairs, ratios, cosines and the internal-reflection flag into the
// reflectance pipeline and checks every result beat against a bit-exact
// fixed-point predictor, in order, under random sender gaps.
// ----------------------------------------------------------------------------
module tb_schlick_fresnel_reflectance_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = sfr_pkg::FRACTION_BITS_DEF;
    localparam int LATENCY = FB + 10;

    typedef struct {
        logic [sfr_pkg::REFL_W-1:0] refl;
        logic                       clamped;
    } t_refl_result;

    class t_reflectance_board;
        t_refl_result pending[$];
        int           errors;

        function automatic longint unsigned isqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned b;
            root = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v -= root + b;
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        function automatic t_refl_result reflect(longint unsigned n1, longint unsigned n2,
                                                 longint unsigned ratio, longint unsigned cs,
                                                 bit tir);
            longint unsigned one, half, diff, total, q, r0, c, c2, t, arg, x, x2, x5, res, o;
            t_refl_result    r;
            one = 64'd1 << FB;
            half = 64'd1 << (FB - 1);
            r.clamped = 1'b0;
            if (n1 > n2 && tir) begin
                r.refl = sfr_pkg::REFL_ONE;
                return r;
            end
            diff = (n1 > n2) ? n1 - n2 : n2 - n1;
            total = n1 + n2;
            r0 = 0;
            if (total != 0) begin
                q = ((diff << FB) + (total >> 1)) / total;
                if (q > one) q = one;
                r0 = (q * q + half) >> FB;
                if (r0 > one) r0 = one;
            end
            if (cs > sfr_pkg::COS_ONE) cs = sfr_pkg::COS_ONE;
            c = (cs << FB) >> 15;
            if (n1 > n2) begin
                c2 = (c * c) >> FB;
                t = (ratio * (one - c2)) >> 13;
                if (t > one) begin
                    arg = 0;
                    r.clamped = 1'b1;
                end else begin
                    arg = one - t;
                end
                c = isqrt(arg << FB);
                if (c > one) c = one;
            end
            x = one - c;
            x2 = (x * x) >> FB;
            x5 = (x2 * x2) >> FB;
            x5 = (x5 * x) >> FB;
            res = r0 + (((one - r0) * x5) >> FB);
            if (res > one) res = one;
            o = ((res << 16) + half) >> FB;
            if (o > 65536) o = 65536;
            r.refl = o[sfr_pkg::REFL_W-1:0];
            return r;
        endfunction

        function void note_beat(logic [15:0] n1, logic [15:0] n2, logic [17:0] ratio,
                                logic [15:0] cs, logic tir);
            pending.insert(pending.size(),
                           reflect(64'(n1), 64'(n2), 64'(ratio), 64'(cs), tir));
        endfunction

        function void check_beat(logic [sfr_pkg::REFL_W-1:0] refl, logic clamped);
            t_refl_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result refl=%0d clamped=%0d", $time, refl, clamped);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (refl !== e.refl) begin
                $display("%0t: reflectance expected %0d actual %0d", $time, e.refl, refl);
                errors++;
            end
            if (clamped !== e.clamped) begin
                $display("%0t: sqrt_clamped expected %0d actual %0d", $time, e.clamped,
                         clamped);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [15:0] i_index_incident;
    logic [15:0] i_index_far;
    logic [17:0] i_ratio_squared;
    logic [15:0] i_cos_incident;
    logic        i_internal_reflection;
    logic        o_done;
    logic [16:0] o_reflectance;
    logic        o_sqrt_clamped;

    t_reflectance_board board;
    int                 idle_pct;

    schlick_fresnel_reflectance_top u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy)
            board.note_beat(i_index_incident, i_index_far, i_ratio_squared, i_cos_incident,
                            i_internal_reflection);
        if (i_rst_n && o_done)
            board.check_beat(o_reflectance, o_sqrt_clamped);
    end

    task automatic send_beat(logic [15:0] n1, logic [15:0] n2, logic [17:0] ratio,
                             logic [15:0] cs, logic tir);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_index_incident <= n1;
        i_index_far <= n2;
        i_ratio_squared <= ratio;
        i_cos_incident <= cs;
        i_internal_reflection <= tir;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic [15:0] n1, n2, cs;
        logic [17:0] ratio;
        int          sel;
        sel = int'($urandom_range(9));
        n1 = 16'($urandom);
        n2 = 16'($urandom_range(65535, 1));
        cs = (sel < 8) ? 16'($urandom_range(32768)) : 16'($urandom);
        if (sel < 6 && n2 != 0) begin
            // physically plausible ratio with a random nudge
            ratio = 18'((64'(n1) * n1 * 8192) / (64'(n2) * n2));
            if ($urandom_range(1)) ratio = 18'(ratio + $urandom_range(64) - 32);
            if ((64'(n1) * n1 * 8192) / (64'(n2) * n2) > 262143) ratio = 18'($urandom);
        end else begin
            ratio = 18'($urandom);
        end
        send_beat(n1, n2, ratio, cs, $urandom_range(3) == 0);
    endtask

    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        board = new();
        idle_pct = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_index_incident = '0;
        i_index_far = 16'd1;
        i_ratio_squared = '0;
        i_cos_incident = '0;
        i_internal_reflection = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(16'd0, 16'd1, 18'd0, 16'd0, 1'b0);
        send_beat(16'd0, 16'hFFFF, 18'h3FFFF, 16'hFFFF, 1'b1);
        send_beat(16'hFFFF, 16'd1, 18'h3FFFF, 16'd0, 1'b1);
        send_beat(16'hFFFF, 16'd1, 18'h3FFFF, 16'd0, 1'b0);
        send_beat(16'hFFFF, 16'hFFFF, 18'd8192, 16'd32768, 1'b1);
        send_beat(16'd12288, 16'd8192, 18'd18432, 16'd32768, 1'b0);
        send_beat(16'd12288, 16'd8192, 18'd18432, 16'd0, 1'b0);
        send_beat(16'd12288, 16'd8192, 18'd18432, 16'd0, 1'b1);
        send_beat(16'd8192, 16'd12288, 18'd3641, 16'd16384, 1'b1);
        send_beat(16'd8192, 16'd12288, 18'd3641, 16'd40000, 1'b0);
        send_beat(16'd8192, 16'd12288, 18'd3641, 16'hFFFF, 1'b0);
        send_beat(16'd12288, 16'd8192, 18'd16384, 16'd0, 1'b0);
        send_beat(16'd12288, 16'd8192, 18'd16385, 16'd0, 1'b0);
        send_beat(16'd12288, 16'd8192, 18'd8192, 16'd0, 1'b0);
        send_beat(16'd12288, 16'd8192, 18'd0, 16'd23170, 1'b0);
        send_beat(16'd8193, 16'd8192, 18'h2AAAA, 16'h5555, 1'b0);
        send_beat(16'd8192, 16'd8192, 18'h15555, 16'hAAAA, 1'b1);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 56;
                2: idle_pct = 28;
                3: idle_pct = 0;
                default: idle_pct = 56;
            endcase
            repeat (210) send_random();
            if (phase == 2) drain();
        end
        drain();
        repeat (LATENCY + 5) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
